### src/hs_pkg.sv
package hs_pkg;

    localparam int QBITS   = 30;
    localparam int SIN_LAT = 9;
    localparam int TOP_LAT = SIN_LAT + 5;

    localparam logic [16:0] FULL_TURN     = 17'd36000;
    localparam logic [16:0] THREE_QUARTER = 17'd27000;
    localparam logic [16:0] HALF_TURN     = 17'd18000;
    localparam logic [16:0] QUARTER_TURN  = 17'd9000;

    localparam logic [36:0] RECIP_K = 37'd125099989649;

    localparam logic [30:0] COEF0 = 31'd1686629713;
    localparam logic [30:0] COEF1 = 31'd693598668;
    localparam logic [30:0] COEF2 = 31'd85569306;
    localparam logic [30:0] COEF3 = 31'd5026995;
    localparam logic [30:0] COEF4 = 31'd172272;
    localparam logic [30:0] QONE  = 31'h4000_0000;

    localparam logic [7:0] CFG_SUN_ELEVATION = 8'd0;
    localparam logic [7:0] CFG_SUN_AZIMUTH   = 8'd1;

endpackage

### src/hs_sin.sv
module hs_sin (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic        [16:0] i_angle,
    output logic signed [31:0] o_sin
);

    logic [16:0] n_a0;
    logic [13:0] n_r;
    logic        n_neg;

    logic [13:0] r1_r;
    logic        r1_neg;
    logic [50:0] r2_prod;
    logic [13:0] r2_r;
    logic        r2_neg;
    logic [30:0] r3_x;
    logic        r3_neg;
    logic [30:0] r4_x2;
    logic [30:0] r4_x;
    logic        r4_neg;
    logic [30:0] r5_p;
    logic [30:0] r5_x2;
    logic [30:0] r5_x;
    logic        r5_neg;
    logic [30:0] r6_p;
    logic [30:0] r6_x2;
    logic [30:0] r6_x;
    logic        r6_neg;
    logic [30:0] r7_p;
    logic [30:0] r7_x2;
    logic [30:0] r7_x;
    logic        r7_neg;
    logic [30:0] r8_p;
    logic [30:0] r8_x;
    logic        r8_neg;
    logic signed [31:0] r9_sin;

    logic [30:0] est;
    logic [44:0] resid;
    logic [30:0] n_x;
    logic [61:0] sq;
    logic [61:0] h5;
    logic [61:0] h6;
    logic [61:0] h7;
    logic [61:0] h8;
    logic [61:0] fin;
    logic [30:0] pm;

    always_comb begin
        n_a0 = (i_angle >= hs_pkg::FULL_TURN) ? i_angle - hs_pkg::FULL_TURN : i_angle;
        priority if (n_a0 >= hs_pkg::THREE_QUARTER) begin
            n_r   = 14'(hs_pkg::FULL_TURN - n_a0);
            n_neg = 1'b1;
        end else if (n_a0 >= hs_pkg::HALF_TURN) begin
            n_r   = 14'(n_a0 - hs_pkg::HALF_TURN);
            n_neg = 1'b1;
        end else if (n_a0 >= hs_pkg::QUARTER_TURN) begin
            n_r   = 14'(hs_pkg::HALF_TURN - n_a0);
            n_neg = 1'b0;
        end else begin
            n_r   = 14'(n_a0);
            n_neg = 1'b0;
        end
    end

    always_comb begin
        est   = r2_prod[50:20];
        resid = {1'b0, r2_r, 30'd0} - 45'(est) * 45'(hs_pkg::QUARTER_TURN);
        n_x   = (resid >= 45'(hs_pkg::QUARTER_TURN)) ? est + 31'd1 : est;
        sq    = 62'(r3_x) * 62'(r3_x);
        h5    = 62'(hs_pkg::COEF4) * 62'(r4_x2);
        h6    = 62'(r5_p) * 62'(r5_x2);
        h7    = 62'(r6_p) * 62'(r6_x2);
        h8    = 62'(r7_p) * 62'(r7_x2);
        fin   = 62'(r8_p) * 62'(r8_x);
        pm    = (fin[60:30] > hs_pkg::QONE) ? hs_pkg::QONE : fin[60:30];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_r    <= n_r;
            r1_neg  <= n_neg;
            r2_prod <= 51'(r1_r) * 51'(hs_pkg::RECIP_K);
            r2_r    <= r1_r;
            r2_neg  <= r1_neg;
            r3_x    <= n_x;
            r3_neg  <= r2_neg;
            r4_x2   <= sq[60:30];
            r4_x    <= r3_x;
            r4_neg  <= r3_neg;
            r5_p    <= hs_pkg::COEF3 - h5[60:30];
            r5_x2   <= r4_x2;
            r5_x    <= r4_x;
            r5_neg  <= r4_neg;
            r6_p    <= hs_pkg::COEF2 - h6[60:30];
            r6_x2   <= r5_x2;
            r6_x    <= r5_x;
            r6_neg  <= r5_neg;
            r7_p    <= hs_pkg::COEF1 - h7[60:30];
            r7_x2   <= r6_x2;
            r7_x    <= r6_x;
            r7_neg  <= r6_neg;
            r8_p    <= hs_pkg::COEF0 - h8[60:30];
            r8_x    <= r7_x;
            r8_neg  <= r7_neg;
            r9_sin  <= r8_neg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
        end
    end

    assign o_sin = r9_sin;

endmodule

### src/hs_mulq.sv
module hs_mulq (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_p
);

    logic [30:0] mag_a;
    logic [30:0] mag_b;
    logic [61:0] prod;
    logic [61:0] rnd;
    logic        neg;
    logic signed [31:0] r_p;

    always_comb begin
        mag_a = i_a[31] ? 31'(-i_a) : i_a[30:0];
        mag_b = i_b[31] ? 31'(-i_b) : i_b[30:0];
        neg   = i_a[31] ^ i_b[31];
        prod  = 62'(mag_a) * 62'(mag_b);
        rnd   = prod + (62'(1) << (hs_pkg::QBITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= neg ? -$signed({1'b0, rnd[60:30]}) : $signed({1'b0, rnd[60:30]});
        end
    end

    assign o_p = r_p;

endmodule

### src/hillshade_pixel.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_valid / o_ready           missing flags, slope, aspect
// result    out        o_valid / i_ready           o_shade, o_shade_nodata
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One request is taken per cycle while the output is not stalled; each accepted request
// passes through 14 register stages: input, diff, the nine-stage sine pipeline,
// two product stages and rounding.
// Reset is synchronous and active low; it clears the valid bits and loads the
// sun registers with 45.00 degrees elevation and 315.00 degrees azimuth.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
module hillshade_pixel #(
    parameter int SHADE_FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_elevation_missing,
    input  logic        i_slope_missing,
    input  logic        i_aspect_missing,
    input  logic [13:0] i_slope_angle,
    input  logic [15:0] i_aspect_angle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_shade,
    output logic        o_shade_nodata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int          LAT  = hs_pkg::TOP_LAT;
    localparam int          DROP = hs_pkg::QBITS - SHADE_FRAC_BITS;
    localparam logic [32:0] HALF = 33'(1) << (DROP - 1);
    localparam logic [32:0] CAP  = 33'(1) << SHADE_FRAC_BITS;

    logic [13:0] r_sun_elev;
    logic [15:0] r_sun_azi;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_nd;
    logic        en;

    logic [13:0] r1_slope;
    logic [15:0] r1_aspect;
    logic [13:0] r1_elev;
    logic [15:0] r1_azi;
    logic [13:0] r2_slope;
    logic [13:0] r2_elev;
    logic [15:0] r2_diff;
    logic [16:0] n_diff;

    logic signed [31:0] cz, sz, cs, ss, cd;
    logic signed [31:0] ma, mb, mc;
    logic signed [31:0] r_cd;
    logic signed [31:0] r_ma;
    logic signed [32:0] t;
    logic [32:0] rs;
    logic [32:0] rc;
    logic [15:0] r_shade;

    assign en          = !r_vld[LAT-1] || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sun_elev <= 14'd4500;
            r_sun_azi  <= 16'd31500;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hs_pkg::CFG_SUN_ELEVATION: r_sun_elev <= i_cfg_data[13:0];
                hs_pkg::CFG_SUN_AZIMUTH:   r_sun_azi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nd <= {r_nd[LAT-2:0],
                     i_elevation_missing | i_slope_missing | i_aspect_missing};
        end
    end

    always_comb begin
        n_diff = 17'(r1_azi) + hs_pkg::FULL_TURN - 17'(r1_aspect);
        if (n_diff >= hs_pkg::FULL_TURN) begin
            n_diff = n_diff - hs_pkg::FULL_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_slope  <= i_slope_angle;
            r1_aspect <= (17'(i_aspect_angle) >= hs_pkg::FULL_TURN) ?
                         16'(17'(i_aspect_angle) - hs_pkg::FULL_TURN) : i_aspect_angle;
            r1_elev   <= r_sun_elev;
            r1_azi    <= (17'(r_sun_azi) >= hs_pkg::FULL_TURN) ?
                         16'(17'(r_sun_azi) - hs_pkg::FULL_TURN) : r_sun_azi;
            r2_slope  <= r1_slope;
            r2_elev   <= r1_elev;
            r2_diff   <= n_diff[15:0];
        end
    end

    hs_sin u_cz (.i_clk(i_clk), .i_en(en), .i_angle(17'(r2_elev)), .o_sin(cz));
    hs_sin u_sz (.i_clk(i_clk), .i_en(en),
                 .i_angle(17'(r2_elev) + hs_pkg::QUARTER_TURN), .o_sin(sz));
    hs_sin u_cs (.i_clk(i_clk), .i_en(en),
                 .i_angle(17'(r2_slope) + hs_pkg::QUARTER_TURN), .o_sin(cs));
    hs_sin u_ss (.i_clk(i_clk), .i_en(en), .i_angle(17'(r2_slope)), .o_sin(ss));
    hs_sin u_cd (.i_clk(i_clk), .i_en(en),
                 .i_angle(17'(r2_diff) + hs_pkg::QUARTER_TURN), .o_sin(cd));

    hs_mulq u_ma (.i_clk(i_clk), .i_en(en), .i_a(cz), .i_b(cs), .o_p(ma));
    hs_mulq u_mb (.i_clk(i_clk), .i_en(en), .i_a(sz), .i_b(ss), .o_p(mb));
    hs_mulq u_mc (.i_clk(i_clk), .i_en(en), .i_a(mb), .i_b(r_cd), .o_p(mc));

    always_comb begin
        t  = 33'(r_ma) + 33'(mc);
        rs = (33'(t) + HALF) >> DROP;
        rc = (rs > CAP) ? CAP : rs;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd <= cd;
            r_ma <= ma;
            if (r_nd[LAT-2] || t <= 33'sd0) begin
                r_shade <= 16'd0;
            end else begin
                r_shade <= (rc > 33'h0FFFF) ? 16'hFFFF : rc[15:0];
            end
        end
    end

    assign o_valid        = r_vld[LAT-1];
    assign o_shade        = r_shade;
    assign o_shade_nodata = r_nd[LAT-1];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld) && $stable(o_shade))
        else $error("pipeline moved during a stall");

    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_shade_nodata |-> o_shade == 16'd0)
        else $error("nodata result with nonzero shade");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 33'(o_shade) <= CAP)
        else $error("shade above one");

    a_accept_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted request not in first stage");

endmodule

### tb/sv/tb_hillshade_pixel.sv
module tb_hillshade_pixel;

    localparam logic [7:0] CFG_SPARE_LO = 8'd2;
    localparam logic [7:0] CFG_SPARE_HI = 8'hFF;
    localparam int FRAC_BITS = 15;
    localparam int DRAIN_CYCLES = hs_pkg::TOP_LAT + 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic        elev_miss;
        logic        slope_miss;
        logic        aspect_miss;
        logic [13:0] slope;
        logic [15:0] aspect;
    } t_cell;

    typedef struct {
        logic [15:0] shade;
        logic        nodata;
    } t_shade;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_elevation_missing;
    logic        i_slope_missing;
    logic        i_aspect_missing;
    logic [13:0] i_slope_angle;
    logic [15:0] i_aspect_angle;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_shade;
    logic        o_shade_nodata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    hillshade_pixel uut (.*);

    t_cell  cell_queue[$];
    t_shade shade_queue[$];
    logic [13:0] sun_elev;
    logic [15:0] sun_azi;
    bit     started;
    bit     calm;
    bit     cell_taken;
    int     send_gap;
    int     recv_gap;
    int     cycles;
    int     errors;
    int     n_cells;
    int     n_nodata;
    int     n_dark;
    int     n_cfg;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint sine_q30(int unsigned ang);
        int unsigned quad;
        int unsigned rem;
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] p;
        ang = ang % 36000;
        quad = ang / 9000;
        rem = ang % 9000;
        if (quad == 1 || quad == 3) rem = 9000 - rem;
        x = (64'(rem) << hs_pkg::QBITS) / 9000;
        x2 = (x * x) >> hs_pkg::QBITS;
        p = 64'(hs_pkg::COEF4);
        p = 64'(hs_pkg::COEF3) - ((p * x2) >> hs_pkg::QBITS);
        p = 64'(hs_pkg::COEF2) - ((p * x2) >> hs_pkg::QBITS);
        p = 64'(hs_pkg::COEF1) - ((p * x2) >> hs_pkg::QBITS);
        p = 64'(hs_pkg::COEF0) - ((p * x2) >> hs_pkg::QBITS);
        p = (p * x) >> hs_pkg::QBITS;
        if (p > 64'(hs_pkg::QONE)) p = 64'(hs_pkg::QONE);
        return (quad >= 2) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint cosine_q30(int unsigned ang);
        return sine_q30((ang % 36000) + 9000);
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        bit [63:0] m;
        bit neg;
        p = a * b;
        neg = p < 0;
        m = neg ? -p : p;
        m = (m + (64'd1 << (hs_pkg::QBITS - 1))) >> hs_pkg::QBITS;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_shade predict_shade(t_cell c);
        t_shade r;
        int unsigned slope, aspect, elev, azi, diff;
        longint t;
        bit [63:0] s;
        r.shade = '0;
        r.nodata = 1'b1;
        if (c.elev_miss || c.slope_miss || c.aspect_miss) return r;
        r.nodata = 1'b0;
        slope = c.slope % 36000;
        aspect = c.aspect % 36000;
        elev = sun_elev % 36000;
        azi = sun_azi % 36000;
        diff = (azi + 36000 - aspect) % 36000;
        t = qmul(sine_q30(elev), cosine_q30(slope))
            + qmul(qmul(cosine_q30(elev), sine_q30(slope)), cosine_q30(diff));
        if (t > 0) begin
            s = (64'(t) + (64'd1 << (hs_pkg::QBITS - FRAC_BITS - 1)))
                >> (hs_pkg::QBITS - FRAC_BITS);
            if (s > (64'd1 << FRAC_BITS)) s = 64'd1 << FRAC_BITS;
            if (s > 64'hFFFF) s = 64'hFFFF;
            r.shade = s[15:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_shade want;
        t_cell c;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        cell_taken = i_valid && o_ready && i_rst_n;
        if (cell_taken) begin
            c.elev_miss = i_elevation_missing;
            c.slope_miss = i_slope_missing;
            c.aspect_miss = i_aspect_missing;
            c.slope = i_slope_angle;
            c.aspect = i_aspect_angle;
            want = predict_shade(c);
            shade_queue = {shade_queue, want};
            n_cells++;
            if (want.nodata) n_nodata++;
            else if (want.shade == 0) n_dark++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (shade_queue.size() == 0) begin
                $error("unexpected request out: shade=%0d nodata=%0b", o_shade, o_shade_nodata);
                errors++;
            end else begin
                want = shade_queue.pop_front();
                if (o_shade !== want.shade) begin
                    $error("shade: expected %0d, actual %0d", want.shade, o_shade);
                    errors++;
                end
                if (o_shade_nodata !== want.nodata) begin
                    $error("shade_nodata: expected %0b, actual %0b", want.nodata,
                           o_shade_nodata);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_cell c;
        if (started) begin
            if (!i_valid || cell_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 13);
                    i_valid <= 1'b0;
                end else if (cell_queue.size() > 0) begin
                    c = cell_queue.pop_front();
                    i_elevation_missing <= c.elev_miss;
                    i_slope_missing <= c.slope_miss;
                    i_aspect_missing <= c.aspect_miss;
                    i_slope_angle <= c.slope;
                    i_aspect_angle <= c.aspect;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 13);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic add_cell(bit em, bit sm, bit am, logic [13:0] sl, logic [15:0] asp);
        t_cell c;
        c.elev_miss = em;
        c.slope_miss = sm;
        c.aspect_miss = am;
        c.slope = sl;
        c.aspect = asp;
        cell_queue = {cell_queue, c};
    endtask

    task automatic add_random_cells(int count);
        repeat (count) begin
            add_cell($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                     $urandom_range(0, 9) == 0,
                     ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 9000)),
                     ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 35999)));
        end
    endtask

    task automatic write_cfg(logic [7:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == hs_pkg::CFG_SUN_ELEVATION) sun_elev = data[13:0];
        else if (idx == hs_pkg::CFG_SUN_AZIMUTH) sun_azi = data;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (cell_queue.size() > 0 || i_valid || shade_queue.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_elevation_missing = 1'b0;
        i_slope_missing = 1'b0;
        i_aspect_missing = 1'b0;
        i_slope_angle = '0;
        i_aspect_angle = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sun_elev = 14'd4500;
        sun_azi = 16'd31500;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        started = 1'b1;

        // Reset sun position first, with the corner cases of the cell fields.
        add_cell(1, 0, 0, 14'd100, 16'd100);
        add_cell(0, 1, 0, 14'd100, 16'd100);
        add_cell(0, 0, 1, 14'd100, 16'd100);
        add_cell(1, 1, 1, 14'h3FFF, 16'hFFFF);
        add_cell(0, 0, 0, 14'd0, 16'd0);
        add_cell(0, 0, 0, 14'd9000, 16'd0);
        add_cell(0, 0, 0, 14'd9000, 16'd31500);
        add_cell(0, 0, 0, 14'd9000, 16'd13500);
        add_cell(0, 0, 0, 14'd6000, 16'd13500);
        add_cell(0, 0, 0, 14'h3FFF, 16'd35999);
        add_cell(0, 0, 0, 14'd4500, 16'hFFFF);
        add_cell(0, 0, 0, 14'd4500, 16'd36000);
        add_cell(0, 0, 0, 14'd1, 16'd1);
        add_cell(0, 0, 0, 14'h2AAA, 16'h5555);
        add_cell(0, 0, 0, 14'h1555, 16'hAAAA);
        add_random_cells(250);
        drain();

        write_cfg(hs_pkg::CFG_SUN_ELEVATION, 16'd0);
        write_cfg(hs_pkg::CFG_SUN_AZIMUTH, 16'd0);
        add_cell(0, 0, 0, 14'd0, 16'd0);
        add_cell(0, 0, 0, 14'd9000, 16'd0);
        add_cell(0, 0, 0, 14'd9000, 16'd18000);
        add_random_cells(250);
        drain();

        write_cfg(hs_pkg::CFG_SUN_ELEVATION, 16'd9000);
        write_cfg(hs_pkg::CFG_SUN_AZIMUTH, 16'd35999);
        add_random_cells(250);
        drain();

        write_cfg(hs_pkg::CFG_SUN_ELEVATION, 16'hFFFF);
        write_cfg(hs_pkg::CFG_SUN_AZIMUTH, 16'hFFFF);
        add_random_cells(250);
        drain();

        write_cfg(CFG_SPARE_LO, 16'h1234);
        write_cfg(CFG_SPARE_HI, 16'hFFFF);
        write_cfg(hs_pkg::CFG_SUN_ELEVATION, 16'd1);
        add_random_cells(200);
        drain();

        repeat (3) begin
            write_cfg(hs_pkg::CFG_SUN_ELEVATION, 16'($urandom_range(0, 9000)));
            write_cfg(hs_pkg::CFG_SUN_AZIMUTH, 16'($urandom_range(0, 35999)));
            add_random_cells(250);
            drain();
        end

        calm = 1'b1;
        send_gap = 0;
        recv_gap = 0;
        write_cfg(hs_pkg::CFG_SUN_ELEVATION, 16'd4500);
        write_cfg(hs_pkg::CFG_SUN_AZIMUTH, 16'd31500);
        add_random_cells(150);
        drain();

        $display("Shaded %0d cells (%0d nodata, %0d fully dark) across %0d register writes.",
                 n_cells, n_nodata, n_dark, n_cfg);
        $display("Sun positions spanned zero, maximum and wrapped register values.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
